@@ design/sliding_window_kth_smallest_assert.svh @@
// Assertion macros used by the RTL.
`ifndef SLIDING_WINDOW_KTH_SMALLEST_ASSERT_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SWK_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define SWK_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ design/swk_pkg.sv @@
`default_nettype none
package swk_pkg;
    localparam int WINDOW_MAX_DEF = 256;
    localparam int K_W            = 9;
    localparam int VAL_W          = 32;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_RIGHT = 2'd1;
    localparam logic [1:0] ACT_LEFT  = 2'd2;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
endpackage
`default_nettype wire

@@ design/swk_if.sv @@
`default_nettype none
interface swk_in_if import swk_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface swk_out_if import swk_pkg::*; #(parameter int CW = 9) ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] kth_value;
    logic [CW-1:0]           window_count;
    modport source (output valid, output status, output kth_value, output window_count,
                    input ready);
    modport sink   (input valid, input status, input kth_value, input window_count,
                    output ready);
endinterface
`default_nettype wire

@@ design/swk_ram.sv @@
`default_nettype none
module swk_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ design/sliding_window_kth_smallest.sv @@
// Start clears the window and stores a value, no result; a right move inserts the
// value, shifting larger sorted entries up; a left move finds the oldest value and
// shifts later entries down; a rejected move (full, empty, bad action) goes to output.
// One item at a time: the sorted store is walked through a single registered read port.
// Reset (synchronous, active low): window empty, rank 1, no result pending.
// Stores are not cleared; only entries written since the last start or reset are read.
`default_nettype none
`include "sliding_window_kth_smallest_assert.svh"
module sliding_window_kth_smallest import swk_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [K_W-1:0]   i_cfg_wdata,
    swk_in_if.sink                i_in,
    swk_out_if.source             o_out
);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int XW = (CW > K_W) ? CW : K_W;
    localparam int SW = CW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ARD    = 4'd1;
    localparam logic [3:0] S_INS_RD = 4'd2;
    localparam logic [3:0] S_INS_CP = 4'd3;
    localparam logic [3:0] S_REM_RD = 4'd4;
    localparam logic [3:0] S_REM_CP = 4'd5;
    localparam logic [3:0] S_SH_RD  = 4'd6;
    localparam logic [3:0] S_SH_WR  = 4'd7;
    localparam logic [3:0] S_RPT    = 4'd8;
    localparam logic [3:0] S_RPT_W  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]              r_state, n_state;
    logic [CW-1:0]           r_fill, n_fill;
    logic [AW-1:0]           r_old, n_old;
    logic [CW-1:0]           r_pos, n_pos;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [1:0]              r_act, n_act;
    logic [K_W-1:0]          r_k;
    logic                    r_ov, n_ov;
    logic [1:0]              r_st, n_st;
    logic signed [VAL_W-1:0] r_kv, n_kv;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [1:0]              r_pst, n_pst;
    logic signed [VAL_W-1:0] r_pkv, n_pkv;

    logic             a_we, a_re, o_we, o_re;
    logic [AW-1:0]    a_waddr, a_raddr, o_waddr, o_raddr;
    logic [VAL_W-1:0] a_wdata, o_wdata, a_rdata, o_rdata;

    logic [SW-1:0] app_sum;
    logic [AW-1:0] app_addr, old_inc;
    logic          short_k, in_acc, out_free;

    swk_ram #(.W(VAL_W), .D(WINDOW_MAX)) u_arrival (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(a_re), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    swk_ram #(.W(VAL_W), .D(WINDOW_MAX)) u_ordered (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_re(o_re), .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign in_acc             = i_in.valid && i_in.ready;
    assign o_out.valid        = r_ov;
    assign o_out.status       = r_st;
    assign o_out.kth_value    = r_kv;
    assign o_out.window_count = r_cnt;
    assign out_free           = !r_ov || o_out.ready;

    always_comb begin
        app_sum = SW'(r_old) + SW'(r_fill);
        if (app_sum >= SW'(WINDOW_MAX)) begin
            app_sum = app_sum - SW'(WINDOW_MAX);
        end
    end
    assign app_addr = app_sum[AW-1:0];
    assign old_inc  = (r_old == AW'(WINDOW_MAX - 1)) ? '0 : r_old + 1'b1;
    assign short_k  = (r_k == '0) || (XW'(r_k) > XW'(r_fill));

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_old   = r_old;
        n_pos   = r_pos;
        n_val   = r_val;
        n_act   = r_act;
        n_ov    = r_ov && !o_out.ready;
        n_st    = r_st;
        n_kv    = r_kv;
        n_cnt   = r_cnt;
        n_pst   = r_pst;
        n_pkv   = r_pkv;
        a_we    = 1'b0;
        a_waddr = app_addr;
        a_wdata = i_in.value;
        a_re    = 1'b0;
        a_raddr = r_old;
        o_we    = 1'b0;
        o_waddr = r_pos[AW-1:0];
        o_wdata = r_val;
        o_re    = 1'b0;
        o_raddr = r_pos[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act = i_in.action;
                    n_val = i_in.value;
                    n_pkv = '0;
                    n_pst = ST_REJECT;
                    case (i_in.action)
                        ACT_START: begin
                            n_old   = '0;
                            n_fill  = '0;
                            n_pos   = '0;
                            a_we    = 1'b1;
                            a_waddr = '0;
                            n_state = S_INS_RD;
                        end
                        ACT_RIGHT: begin
                            if (r_fill == CW'(WINDOW_MAX)) begin
                                n_state = S_OUT;
                            end else begin
                                a_we    = 1'b1;
                                n_pos   = r_fill;
                                n_state = S_INS_RD;
                            end
                        end
                        ACT_LEFT: begin
                            if (r_fill == '0) begin
                                n_state = S_OUT;
                            end else begin
                                a_re    = 1'b1;
                                n_state = S_ARD;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    o_we   = 1'b1;
                    n_fill = r_fill + 1'b1;
                    n_state = (r_act == ACT_START) ? S_IDLE : S_RPT;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_pos - 1'b1);
                    n_state = S_INS_CP;
                end
            end
            S_INS_CP: begin
                o_we = 1'b1;
                if ($signed(o_rdata) > r_val) begin
                    o_wdata = o_rdata;
                    n_pos   = r_pos - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_fill  = r_fill + 1'b1;
                    n_state = (r_act == ACT_START) ? S_IDLE : S_RPT;
                end
            end
            S_ARD: begin
                n_val   = a_rdata;
                n_pos   = '0;
                n_state = S_REM_RD;
            end
            S_REM_RD: begin
                o_re    = 1'b1;
                n_state = S_REM_CP;
            end
            S_REM_CP: begin
                if ($signed(o_rdata) == r_val) begin
                    n_state = S_SH_RD;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = (r_pos + 1'b1 >= r_fill) ? S_SH_RD : S_REM_RD;
                end
            end
            S_SH_RD: begin
                if (SW'(r_pos) + 1'b1 < SW'(r_fill)) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(r_pos + 1'b1);
                    n_state = S_SH_WR;
                end else begin
                    n_fill  = r_fill - 1'b1;
                    n_old   = old_inc;
                    n_state = S_RPT;
                end
            end
            S_SH_WR: begin
                o_we    = 1'b1;
                o_wdata = o_rdata;
                n_pos   = r_pos + 1'b1;
                n_state = S_SH_RD;
            end
            S_RPT: begin
                if (short_k) begin
                    n_pst   = ST_SHORT;
                    n_state = S_OUT;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = AW'(XW'(r_k) - 1'b1);
                    n_state = S_RPT_W;
                end
            end
            S_RPT_W: begin
                n_pst   = ST_FOUND;
                n_pkv   = o_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_st    = r_pst;
                    n_kv    = r_pkv;
                    n_cnt   = r_fill;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_old   <= '0;
            r_k     <= K_W'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_old   <= n_old;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
        end
        r_pos <= n_pos;
        r_val <= n_val;
        r_act <= n_act;
        r_st  <= n_st;
        r_kv  <= n_kv;
        r_cnt <= n_cnt;
        r_pst <= n_pst;
        r_pkv <= n_pkv;
    end

    `SWK_ASSERT_NOW(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= CW'(WINDOW_MAX))
    `SWK_ASSERT_NOW(a_kv_zero, i_clk, i_rst_n, r_ov && r_st != ST_FOUND, r_kv == '0)
    `SWK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && !o_out.ready,
                     r_ov && $stable(r_kv) && $stable(r_st))
    `SWK_ASSERT_NEXT(a_start_fill, i_clk, i_rst_n,
                     in_acc && i_in.action == ACT_START, r_fill == '0)
endmodule
`default_nettype wire
